// ===== hdl/tfas_pkg.sv =====
// shared constants, register codes and fixed-point helpers for the
// triple-field acceleration stencil core; no dependencies
package tfas_pkg;

    localparam int DATA_W = 32;
    localparam int IDX_W = 12;
    localparam int CFG_IDX_W = 3;
    localparam int DEF_MAX_POINTS = 4096;

    localparam logic signed [64:0] Q_ONE = 65'sd1048576;
    localparam logic signed [64:0] Q_HALF = 65'sd524288;
    localparam logic signed [64:0] SAT_MAX = 65'sd2147483647;
    localparam logic signed [64:0] SAT_MIN = -65'sd2147483648;

    localparam logic signed [DATA_W-1:0] RST_IDX2 = 32'sd419220685;
    localparam logic signed [DATA_W-1:0] RST_M2 = 32'sd1048576;
    localparam logic signed [DATA_W-1:0] RST_LAMBDA = 32'sd0;
    localparam logic signed [DATA_W-1:0] RST_MU = -32'sd20971520;
    localparam logic signed [DATA_W-1:0] RST_KAPPA = 32'sd20971520;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX2 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_M2 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_LAMBDA = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MU = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KAPPA = 3'd4;

    typedef logic signed [DATA_W-1:0] t_q;

    function automatic t_q sat_q(input logic signed [64:0] v);
        if (v > SAT_MAX) begin
            return t_q'(SAT_MAX);
        end else if (v < SAT_MIN) begin
            return t_q'(SAT_MIN);
        end
        return v[DATA_W-1:0];
    endfunction

    // round half up at bit 20, then saturate
    function automatic t_q mulq(input logic signed [63:0] p);
        logic signed [64:0] s;
        s = 65'(p) + Q_HALF;
        return sat_q(s >>> 20);
    endfunction

endpackage

// ===== hdl/triple_field_acceleration_stencil_core.sv =====
// triple-field acceleration stencil: window, shared multiplier,
// bit-serial divider and sequencer; depends on tfas_pkg
// work: an interior result takes 21 products, in turn on the one shared multiplier, plus
//   three divisions on the one-bit-per-cycle divider, each skipped when the divisor is zero;
//   a point giving only a zero result needs neither
// throughput: one item at a time; the input stalls until the point's results are out, and
//   output stalls can hold it
// reset: synchronous active low, config registers back to defaults, old and mid window zeroed
module triple_field_acceleration_stencil_core
    import tfas_pkg::*;
#(
    parameter int MAX_POINTS = DEF_MAX_POINTS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic signed [31:0]   i_field_one,
    input  logic signed [31:0]   i_field_two,
    input  logic signed [31:0]   i_field_three,
    input  logic                 i_row_start,
    input  logic                 i_row_end,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic signed [31:0]   o_accel_one,
    output logic signed [31:0]   o_accel_two,
    output logic signed [31:0]   o_accel_three,
    output logic [IDX_W-1:0]     o_point_index,
    output logic                 o_run_last,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [31:0]          i_cfg_data
);

    localparam int CW = $clog2(MAX_POINTS);
    localparam int PW = (CW > IDX_W) ? CW : IDX_W;
    localparam logic [CW-1:0] LAST_IDX = CW'(MAX_POINTS - 1);
    localparam int DVD_W = DATA_W + 20;
    localparam logic [5:0] DIV_STEPS = 6'(DVD_W);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_MUL  = 3'd1;
    localparam logic [2:0] S_WB   = 3'd2;
    localparam logic [2:0] S_DIV  = 3'd3;
    localparam logic [2:0] S_EMI  = 3'd4;
    localparam logic [2:0] S_EMZ  = 3'd5;
    localparam logic [2:0] S_FIN  = 3'd6;

    localparam logic [3:0] OP_F01  = 4'd0;
    localparam logic [3:0] OP_P    = 4'd1;
    localparam logic [3:0] OP_P2   = 4'd2;
    localparam logic [3:0] OP_D    = 4'd3;
    localparam logic [3:0] OP_DEN  = 4'd4;
    localparam logic [3:0] OP_NMU  = 4'd5;
    localparam logic [3:0] OP_DP   = 4'd6;
    localparam logic [3:0] OP_NUM  = 4'd7;
    localparam logic [3:0] OP_LAP  = 4'd8;
    localparam logic [3:0] OP_MASS = 4'd9;
    localparam logic [3:0] OP_PAIR = 4'd10;

    logic [2:0] r_state;
    logic [3:0] r_op;
    logic [1:0] r_fld;

    t_q r_idx2, r_m2, r_lambda, r_mu, r_kappa;
    t_q r_old [3];
    t_q r_mid [3];
    t_q r_cur [3];
    t_q r_acc_out [3];
    logic [CW-1:0] r_seen;
    logic [CW-1:0] r_idx;
    logic r_last, r_has_zero;

    t_q r_t, r_p, r_p2, r_d, r_den, r_nmu;
    logic signed [63:0] r_prod;
    logic signed [34:0] r_acc;

    logic [31:0] r_rem;
    logic [DVD_W-1:0] r_dq;
    logic [31:0] r_dvs;
    logic r_dneg;
    logic [5:0] r_cnt;

    logic r_out_valid;
    t_q r_o1, r_o2, r_o3;
    logic [IDX_W-1:0] r_oidx;
    logic r_olast;

    logic in_acc, out_free, emit_go;
    logic [CW-1:0] n_idx;
    logic n_last;
    logic [1:0] fb, fc;
    t_q opa, opb, mq, lap, pairsum, negmu, div_res;
    logic [PW-1:0] idx_ext, int_ext;
    logic [32:0] div_t;
    logic div_ge;
    logic [31:0] num_mag;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall = (r_state != S_IDLE);
    assign in_acc = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign emit_go = ((r_state == S_EMI) || (r_state == S_EMZ)) && out_free;

    assign o_out_valid = r_out_valid;
    assign o_accel_one = r_o1;
    assign o_accel_two = r_o2;
    assign o_accel_three = r_o3;
    assign o_point_index = r_oidx;
    assign o_run_last = r_olast;

    assign n_idx = i_row_start ? '0 : r_seen;
    assign n_last = i_row_end || (n_idx >= LAST_IDX);

    assign idx_ext = PW'(r_idx);
    assign int_ext = PW'(r_idx - CW'(1));

    always_comb begin
        case (r_fld)
            2'd0: begin fb = 2'd1; fc = 2'd2; end
            2'd1: begin fb = 2'd2; fc = 2'd0; end
            default: begin fb = 2'd0; fc = 2'd1; end
        endcase
    end

    assign lap = sat_q(65'(r_old[r_fld]) - 65'(r_mid[r_fld]) - 65'(r_mid[r_fld])
                       + 65'(r_cur[r_fld]));
    assign pairsum = sat_q(65'(r_mid[fb]) + 65'(r_mid[fc]));
    assign negmu = sat_q(65'sd0 - 65'(r_mu));
    assign mq = mulq(r_prod);
    assign num_mag = mq[31] ? (32'd0 - 32'(mq)) : 32'(mq);

    // operand select for the shared multiplier
    always_comb begin
        case (r_op)
            OP_F01:  begin opa = r_mid[0]; opb = r_mid[1]; end
            OP_P:    begin opa = r_t;      opb = r_mid[2]; end
            OP_P2:   begin opa = r_p;      opb = r_p;      end
            OP_D:    begin opa = r_kappa;  opb = r_p2;     end
            OP_DEN:  begin opa = r_d;      opb = r_d;      end
            OP_NMU:  begin opa = negmu;    opb = r_p;      end
            OP_DP:   begin opa = r_mid[fb]; opb = r_mid[fc]; end
            OP_NUM:  begin opa = r_nmu;    opb = r_t;      end
            OP_LAP:  begin opa = r_idx2;   opb = lap;      end
            OP_MASS: begin opa = r_m2;     opb = r_mid[r_fld]; end
            OP_PAIR: begin opa = r_lambda; opb = pairsum;  end
            default: begin opa = '0;       opb = '0;       end
        endcase
    end

    assign div_t = {r_rem, r_dq[DVD_W-1]};
    assign div_ge = (div_t >= {1'b0, r_dvs});

    always_comb begin
        if (r_dneg) begin
            if (r_dq > DVD_W'(33'h080000000)) begin
                div_res = t_q'(SAT_MIN);
            end else begin
                div_res = t_q'(DVD_W'(0) - r_dq);
            end
        end else if (r_dq > DVD_W'(32'h7fffffff)) begin
            div_res = t_q'(SAT_MAX);
        end else begin
            div_res = t_q'(r_dq);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx2 <= RST_IDX2;
            r_m2 <= RST_M2;
            r_lambda <= RST_LAMBDA;
            r_mu <= RST_MU;
            r_kappa <= RST_KAPPA;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_IDX2:   r_idx2 <= i_cfg_data;
                CFG_M2:     r_m2 <= i_cfg_data;
                CFG_LAMBDA: r_lambda <= i_cfg_data;
                CFG_MU:     r_mu <= i_cfg_data;
                CFG_KAPPA:  r_kappa <= i_cfg_data;
                default: begin end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_op <= OP_F01;
            r_fld <= 2'd0;
            r_seen <= '0;
            r_out_valid <= 1'b0;
            for (int k = 0; k < 3; k++) begin
                r_old[k] <= '0;
                r_mid[k] <= '0;
            end
        end else begin
            if (emit_go) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_cur[0] <= i_field_one;
                        r_cur[1] <= i_field_two;
                        r_cur[2] <= i_field_three;
                        r_idx <= n_idx;
                        r_last <= n_last;
                        r_has_zero <= (n_idx == '0) || n_last;
                        r_op <= OP_F01;
                        r_fld <= 2'd0;
                        if (n_idx >= CW'(2)) begin
                            r_state <= S_MUL;
                        end else if ((n_idx == '0) || n_last) begin
                            r_state <= S_EMZ;
                        end else begin
                            r_state <= S_FIN;
                        end
                    end
                end
                S_MUL: begin
                    r_prod <= opa * opb;
                    r_state <= S_WB;
                end
                S_WB: begin
                    if (!(r_op inside {OP_NUM, OP_PAIR})) begin
                        r_state <= S_MUL;
                        r_op <= r_op + 4'd1;
                    end
                    case (r_op)
                        OP_F01: r_t <= mq;
                        OP_P:   r_p <= mq;
                        OP_P2:  r_p2 <= mq;
                        OP_D:   r_d <= sat_q(Q_ONE + 65'(mq));
                        OP_DEN: r_den <= mq;
                        OP_NMU: r_nmu <= mq;
                        OP_DP:  r_t <= mq;
                        OP_NUM: begin
                            r_op <= OP_LAP;
                            if (r_den == '0) begin
                                r_state <= S_MUL;
                                if (mq[31]) begin
                                    r_acc <= 35'(t_q'(SAT_MIN));
                                end else if (mq != '0) begin
                                    r_acc <= 35'(t_q'(SAT_MAX));
                                end else begin
                                    r_acc <= '0;
                                end
                            end else begin
                                r_rem <= '0;
                                r_dq <= {num_mag, 20'd0};
                                r_dvs <= r_den[31] ? (32'd0 - 32'(r_den)) : 32'(r_den);
                                r_dneg <= mq[31] ^ r_den[31];
                                r_cnt <= DIV_STEPS;
                                r_state <= S_DIV;
                            end
                        end
                        OP_LAP:  r_acc <= r_acc + 35'(mq);
                        OP_MASS: r_acc <= r_acc - 35'(mq);
                        OP_PAIR: begin
                            r_acc_out[r_fld] <= sat_q(65'(r_acc) - 65'(mq));
                            if (r_fld == 2'd2) begin
                                r_state <= S_EMI;
                            end else begin
                                r_state <= S_MUL;
                                r_fld <= r_fld + 2'd1;
                                r_op <= OP_DP;
                            end
                        end
                        default: begin end
                    endcase
                end
                S_DIV: begin
                    if (r_cnt == '0) begin
                        r_acc <= 35'(div_res);
                        r_state <= S_MUL;
                    end else begin
                        r_rem <= div_ge ? (div_t[31:0] - r_dvs) : div_t[31:0];
                        r_dq <= {r_dq[DVD_W-2:0], div_ge};
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                S_EMI: begin
                    if (out_free) begin
                        r_o1 <= r_acc_out[0];
                        r_o2 <= r_acc_out[1];
                        r_o3 <= r_acc_out[2];
                        r_oidx <= int_ext[IDX_W-1:0];
                        r_olast <= !r_has_zero;
                        r_state <= r_has_zero ? S_EMZ : S_FIN;
                    end
                end
                S_EMZ: begin
                    if (out_free) begin
                        r_o1 <= '0;
                        r_o2 <= '0;
                        r_o3 <= '0;
                        r_oidx <= idx_ext[IDX_W-1:0];
                        r_olast <= 1'b1;
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    for (int k = 0; k < 3; k++) begin
                        r_old[k] <= r_mid[k];
                        r_mid[k] <= r_cur[k];
                    end
                    r_seen <= r_last ? '0 : (r_idx + CW'(1));
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    a_div_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_dvs != '0))
        else $error("divider running on zero divisor");

    a_busy_after_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> o_in_stall)
        else $error("item taken while idle did not start work");

    a_fld_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MUL) |-> (r_fld != 2'd3))
        else $error("field counter out of range");

    a_emit_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_EMZ) && r_out_valid && i_out_stall) |=> (r_state == S_EMZ))
        else $error("result dropped while output held");

endmodule
